// ===== sv/crlfd_pkg.sv =====
// Shared constants for the CRLF line deframer: control byte codes,
// configuration width and reset value. No dependencies.
package crlfd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CFG_W  = 16;

  localparam logic [BYTE_W-1:0] BYTE_NUL = 8'h00;
  localparam logic [BYTE_W-1:0] BYTE_LF  = 8'h0A;
  localparam logic [BYTE_W-1:0] BYTE_CR  = 8'h0D;

  localparam logic [CFG_W-1:0] MAX_LINE_RESET = 16'd1998;

endpackage

// ===== sv/crlf_line_deframer.sv =====
// CRLF line deframer top level: byte classification, line state and a
// three-entry result queue. Depends on crlfd_pkg.
//
// Results are registered into the result queue; entry 0 drives the out_ side.
// Throughput: one input beat per cycle while the queue has room for two results;
// a two-result beat (a held CR released ahead of a data byte) can raise in_stall
// until the queue, draining one result per unstalled cycle, has room again.
// Reset (rst_n low, synchronous): queue empty, no CR held, length, overflow
// flag and totals zero, max_line_len back to 1998.
module crlf_line_deframer #(
  parameter int unsigned LEN_WIDTH   = 16,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [crlfd_pkg::CFG_W-1:0]     cfg_max_line_len,
  // input byte channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [crlfd_pkg::BYTE_W-1:0]    in_byte,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_is_line_end,
  output logic [crlfd_pkg::BYTE_W-1:0]    out_byte,
  output logic                            out_ended_by_crlf,
  output logic                            out_line_truncated,
  output logic [LEN_WIDTH-1:0]            out_line_length,
  output logic [COUNT_WIDTH-1:0]          out_crlf_total,
  output logic [COUNT_WIDTH-1:0]          out_lf_total,
  output logic                            out_last_of_run
);
  import crlfd_pkg::*;

  // Width for comparing the kept length against the 16-bit limit.
  localparam int unsigned CMP_W = (LEN_WIDTH > CFG_W) ? LEN_WIDTH : CFG_W;
  localparam int unsigned QDEPTH = 3;

  typedef struct packed {
    logic                   is_line_end;
    logic [BYTE_W-1:0]      data;
    logic                   ended_by_crlf;
    logic                   truncated;
    logic [LEN_WIDTH-1:0]   length;
    logic [COUNT_WIDTH-1:0] crlf_total;
    logic [COUNT_WIDTH-1:0] lf_total;
    logic                   last;
  } result_t;

  // ---------------------------------------------------------------------
  // Configuration: always ready; write only while the block is idle (unchecked).
  // ---------------------------------------------------------------------
  logic [CFG_W-1:0] max_len_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LINE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_len_r <= cfg_max_line_len;
    end
  end

  // ---------------------------------------------------------------------
  // Line state
  // ---------------------------------------------------------------------
  logic                   cr_held_r,  cr_held_nxt;
  logic [LEN_WIDTH-1:0]   kept_r,     kept_nxt;
  logic                   ovf_r,      ovf_nxt;
  logic [COUNT_WIDTH-1:0] crlf_cnt_r, crlf_cnt_nxt;
  logic [COUNT_WIDTH-1:0] lf_cnt_r,   lf_cnt_nxt;

  // Result queue: entry 0 drives the out_ ports.
  result_t     q_r   [QDEPTH];
  result_t     q_nxt [QDEPTH];
  logic [1:0]  cnt_r, cnt_nxt;

  logic in_acc, out_acc;

  // Accept only with room for two results.
  assign in_stall  = (cnt_r > 2'd1);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (cnt_r != 2'd0);
  assign out_acc   = out_valid && !out_stall;

  // ---------------------------------------------------------------------
  // Classify the byte and work out up to two results
  // ---------------------------------------------------------------------
  logic                 is_nul, is_lf, is_cr;
  logic                 cr_data, byte_data, end_line;
  logic                 room_a, room_b, emit_a, emit_b;
  logic [LEN_WIDTH-1:0] kept_a, kept_b;
  logic [1:0]           n_res;
  result_t              res0, res1, data_cr, data_in, end_res;

  always_comb begin
    is_nul    = (in_byte == BYTE_NUL);
    is_lf     = (in_byte == BYTE_LF);
    is_cr     = (in_byte == BYTE_CR);
    end_line  = is_lf;
    // Release the held CR as data unless LF completes the pair or the byte is NUL.
    cr_data   = cr_held_r && !is_lf && !is_nul;
    byte_data = !is_lf && !is_cr && !is_nul;

    // Room check: under the limit and under the length counter's top.
    room_a = (CMP_W'(kept_r) < CMP_W'(max_len_r)) && !(&kept_r);
    emit_a = cr_data && room_a;
    kept_a = kept_r + LEN_WIDTH'(emit_a);
    room_b = (CMP_W'(kept_a) < CMP_W'(max_len_r)) && !(&kept_a);
    emit_b = byte_data && room_b;
    kept_b = kept_a + LEN_WIDTH'(emit_b);

    // Saturating totals, bumped on a line end.
    crlf_cnt_nxt = crlf_cnt_r;
    lf_cnt_nxt   = lf_cnt_r;
    if (end_line) begin
      if (cr_held_r) begin
        if (!(&crlf_cnt_r)) crlf_cnt_nxt = crlf_cnt_r + COUNT_WIDTH'(1);
      end else begin
        if (!(&lf_cnt_r)) lf_cnt_nxt = lf_cnt_r + COUNT_WIDTH'(1);
      end
    end

    data_cr               = '0;
    data_cr.data          = BYTE_CR;
    data_cr.crlf_total    = crlf_cnt_r;
    data_cr.lf_total      = lf_cnt_r;

    data_in               = '0;
    data_in.data          = in_byte;
    data_in.crlf_total    = crlf_cnt_r;
    data_in.lf_total      = lf_cnt_r;

    end_res               = '0;
    end_res.is_line_end   = 1'b1;
    end_res.ended_by_crlf = cr_held_r;
    end_res.truncated     = ovf_r;
    end_res.length        = kept_r;
    end_res.crlf_total    = crlf_cnt_nxt;
    end_res.lf_total      = lf_cnt_nxt;

    // Order: released CR first, then the byte's own result.
    res1 = data_in;
    if (emit_a) begin
      res0  = data_cr;
      n_res = emit_b ? 2'd2 : 2'd1;
    end else if (end_line) begin
      res0  = end_res;
      n_res = 2'd1;
    end else begin
      res0  = data_in;
      n_res = emit_b ? 2'd1 : 2'd0;
    end
    res0.last = (n_res == 2'd1);
    res1.last = 1'b1;

    // Next line state
    if (is_nul) begin
      cr_held_nxt = cr_held_r;
      kept_nxt    = kept_r;
      ovf_nxt     = ovf_r;
    end else if (end_line) begin
      cr_held_nxt = 1'b0;
      kept_nxt    = '0;
      ovf_nxt     = 1'b0;
    end else begin
      cr_held_nxt = is_cr;
      kept_nxt    = kept_b;
      ovf_nxt     = ovf_r || (cr_data && !room_a) || (byte_data && !room_b);
    end
  end

  // ---------------------------------------------------------------------
  // Queue update: shift on a pop, append new results behind what stays.
  // ---------------------------------------------------------------------
  logic [1:0] base;

  always_comb begin
    base = cnt_r - {1'b0, out_acc};
    for (int i = 0; i < QDEPTH; i++) begin
      q_nxt[i] = q_r[i];
    end
    if (out_acc) begin
      for (int i = 0; i < QDEPTH - 1; i++) begin
        q_nxt[i] = q_r[i+1];
      end
    end
    if (in_acc) begin
      for (int i = 0; i < QDEPTH; i++) begin
        if ((2'(i) == base) && (n_res != 2'd0))            q_nxt[i] = res0;
        if ((2'(i) == base + 2'd1) && (n_res == 2'd2))     q_nxt[i] = res1;
      end
    end
    cnt_nxt = base + (in_acc ? n_res : 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      cr_held_r  <= 1'b0;
      kept_r     <= '0;
      ovf_r      <= 1'b0;
      crlf_cnt_r <= '0;
      lf_cnt_r   <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (in_acc) begin
        cr_held_r  <= cr_held_nxt;
        kept_r     <= kept_nxt;
        ovf_r      <= ovf_nxt;
        crlf_cnt_r <= crlf_cnt_nxt;
        lf_cnt_r   <= lf_cnt_nxt;
      end
    end
  end

  // Payload: no reset needed.
  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  assign out_is_line_end    = q_r[0].is_line_end;
  assign out_byte           = q_r[0].data;
  assign out_ended_by_crlf  = q_r[0].ended_by_crlf;
  assign out_line_truncated = q_r[0].truncated;
  assign out_line_length    = q_r[0].length;
  assign out_crlf_total     = q_r[0].crlf_total;
  assign out_lf_total       = q_r[0].lf_total;
  assign out_last_of_run    = q_r[0].last;

endmodule

// ===== bench/tb_crlf_line_deframer.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for crlf_line_deframer: byte beats in, data and line-end results out.
// Depends on crlfd_pkg and the crlf_line_deframer RTL; needs nothing else to run.
module tb_crlf_line_deframer;
  import crlfd_pkg::*;

  localparam int unsigned LEN_W         = 16;
  localparam int unsigned CNT_W         = 32;
  localparam int unsigned CYCLE_LIMIT   = 2_000_000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned PHASE_BYTES   = 130;
  localparam int unsigned LONG_LINE     = 260;
  localparam logic [CFG_W-1:0] LONG_LIMIT = 16'd200;

  typedef logic [BYTE_W-1:0] byte_t;

  // One result beat as the block presents it, in port order.
  typedef struct packed {
    logic             is_end;
    byte_t            data;
    logic             by_crlf;
    logic             truncated;
    logic [LEN_W-1:0] length;
    logic [CNT_W-1:0] crlf_total;
    logic [CNT_W-1:0] lf_total;
    logic             last;
  } line_result_t;

  // Every block input is known from time zero.
  logic             clk              = 1'b0;
  logic             rst_n            = 1'b0;
  logic             cfg_valid        = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_max_line_len = '0;
  logic             in_valid         = 1'b0;
  logic             in_stall;
  byte_t            in_byte          = '0;
  logic             out_valid;
  logic             out_stall        = 1'b0;
  logic             out_is_line_end;
  byte_t            out_byte;
  logic             out_ended_by_crlf;
  logic             out_line_truncated;
  logic [LEN_W-1:0] out_line_length;
  logic [CNT_W-1:0] out_crlf_total;
  logic [CNT_W-1:0] out_lf_total;
  logic             out_last_of_run;

  crlf_line_deframer #(
    .LEN_WIDTH  (LEN_W),
    .COUNT_WIDTH(CNT_W)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_max_line_len  (cfg_max_line_len),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_byte           (in_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_is_line_end   (out_is_line_end),
    .out_byte          (out_byte),
    .out_ended_by_crlf (out_ended_by_crlf),
    .out_line_truncated(out_line_truncated),
    .out_line_length   (out_line_length),
    .out_crlf_total    (out_crlf_total),
    .out_lf_total      (out_lf_total),
    .out_last_of_run   (out_last_of_run)
  );

  // 10 ns clock: high half, then low half.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Line predictor: its own copy of the deframer state, advanced once per
  // accepted input beat. It appends the results each beat must produce.
  // ---------------------------------------------------------------------------
  logic             cr_pending  = 1'b0;
  logic [LEN_W-1:0] kept_len    = '0;
  logic             line_over   = 1'b0;
  logic [CNT_W-1:0] crlf_seen   = '0;
  logic [CNT_W-1:0] lf_seen     = '0;
  logic [CFG_W-1:0] line_limit  = MAX_LINE_RESET;

  line_result_t pending_results[$];

  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned bytes_sent     = 0;
  bit          gaps_on        = 1'b1;
  bit          stalls_on      = 1'b1;
  int unsigned stall_left     = 0;

  // Keep a data byte if the line has room; otherwise drop it and mark the
  // line truncated. A released CR goes through here as well.
  function automatic void keep_byte(input byte_t b, inout int unsigned n);
    line_result_t r;
    if (kept_len < line_limit && kept_len != '1) begin
      kept_len++;
      r = '0;
      r.data = b;
      r.crlf_total = crlf_seen;
      r.lf_total = lf_seen;
      pending_results.push_back(r);
      n++;
    end else begin
      line_over = 1'b1;
    end
  endfunction

  // Close the current line: bump the matching total (it sticks at all ones),
  // report length and truncation, then start a fresh line.
  function automatic void close_line(input logic by_crlf, inout int unsigned n);
    line_result_t r;
    if (by_crlf) begin
      if (crlf_seen != '1) crlf_seen++;
    end else if (lf_seen != '1) begin
      lf_seen++;
    end
    r = '0;
    r.is_end = 1'b1;
    r.by_crlf = by_crlf;
    r.truncated = line_over;
    r.length = kept_len;
    r.crlf_total = crlf_seen;
    r.lf_total = lf_seen;
    pending_results.push_back(r);
    kept_len = '0;
    line_over = 1'b0;
    n++;
  endfunction

  function automatic void predict_line_results(input byte_t b);
    int unsigned  n = 0;
    line_result_t r;
    // NUL vanishes without touching anything, so a held CR stays held.
    if (b == BYTE_NUL) return;
    if (cr_pending) begin
      cr_pending = 1'b0;
      if (b == BYTE_LF) begin
        close_line(1'b1, n);
      end else begin
        // Release the held CR as data ahead of whatever follows it.
        keep_byte(BYTE_CR, n);
        if (b == BYTE_CR) cr_pending = 1'b1;
        else keep_byte(b, n);
      end
    end else if (b == BYTE_LF) begin
      close_line(1'b0, n);
    end else if (b == BYTE_CR) begin
      cr_pending = 1'b1;
    end else begin
      keep_byte(b, n);
    end
    // Flag the final result of this beat.
    if (n != 0) begin
      r = pending_results.pop_back();
      r.last = 1'b1;
      pending_results.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Idle patterns shared by both sides: mostly short, now and then long.
  // ---------------------------------------------------------------------------
  function automatic int unsigned pick_burst();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 75) return $urandom_range(1, 3);
    if (pick < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Hold out_stall for random bursts; start no new burst while stalls are off.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (stalls_on && $urandom_range(0, 99) < 20) begin
      stall_left = pick_burst() - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: compare every accepted result beat against the oldest
  // prediction, field by field.
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    line_result_t got;
    line_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_is_line_end, out_byte, out_ended_by_crlf, out_line_truncated,
              out_line_length, out_crlf_total, out_lf_total, out_last_of_run};
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing expected, expected none, actual 0x%0h",
                 $time, got);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("is_line_end",    32'(want.is_end),    32'(got.is_end));
        check_field("out_byte",       32'(want.data),      32'(got.data));
        check_field("ended_by_crlf",  32'(want.by_crlf),   32'(got.by_crlf));
        check_field("line_truncated", 32'(want.truncated), 32'(got.truncated));
        check_field("line_length",    32'(want.length),    32'(got.length));
        check_field("crlf_total",     want.crlf_total,     got.crlf_total);
        check_field("lf_total",       want.lf_total,       got.lf_total);
        check_field("last_of_run",    32'(want.last),      32'(got.last));
      end
    end
  end

  // Watchdog: a hung handshake or a missing result ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still expected", $time, pending_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Send one byte beat: optional random gap, then hold the beat until the
  // block takes it. Valid stays high afterwards so back-to-back beats keep
  // the link busy; the next call or go_idle decides what comes next.
  task automatic send_byte(input byte_t b);
    int unsigned gap;
    gap = (gaps_on && $urandom_range(0, 99) < 30) ? pick_burst() : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_line_results(b);
    if (b != BYTE_NUL) bytes_sent++;
  endtask

  task automatic go_idle();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Stop sending, let every expected result drain, then let beats that
  // produce nothing (held CR, NUL) settle.
  task automatic wait_drain();
    go_idle();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write max_line_len; only ever done with the block drained.
  task automatic write_max_len(input logic [CFG_W-1:0] value);
    wait_drain();
    @(negedge clk);
    cfg_valid        <= 1'b1;
    cfg_max_line_len <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    line_limit = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_bytes(input byte_t seq[$]);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // Line text: mostly printable, with stray CRs, NULs and arbitrary bytes.
  function automatic byte_t random_text_byte();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 78) return byte_t'($urandom_range(8'h20, 8'h7E));
    if (pick < 86) return BYTE_CR;
    if (pick < 91) return BYTE_NUL;
    return byte_t'($urandom_range(1, 255));
  endfunction

  // One well-formed line most of the time; otherwise a burst of raw noise or
  // a line with its ending left off so it runs into the next one.
  task automatic send_random_line();
    int unsigned pick;
    int unsigned len;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      repeat ($urandom_range(1, 8)) send_byte(byte_t'($urandom_range(0, 255)));
      return;
    end
    if (pick < 60) len = $urandom_range(0, 10);
    else if (pick < 90) len = (line_limit <= 64) ? $urandom_range(0, line_limit + 3)
                                                 : $urandom_range(0, 40);
    else len = $urandom_range(0, 90);
    repeat (len) send_byte(random_text_byte());
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      send_byte(BYTE_CR);
      send_byte(BYTE_LF);
    end else if (pick < 85) begin
      send_byte(BYTE_LF);
    end else if (pick < 95) begin
      send_byte(BYTE_CR);
      send_byte(BYTE_NUL);
      send_byte(BYTE_LF);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Line endings and byte extremes at the reset length limit.
  task automatic test_directed_endings();
    send_bytes('{8'h41, 8'h42, BYTE_LF});             // lone LF
    send_bytes('{8'h78, BYTE_CR, BYTE_LF});           // CR LF
    send_bytes('{BYTE_CR, BYTE_NUL, BYTE_LF});        // NUL between CR and LF
    send_bytes('{BYTE_CR, BYTE_CR, BYTE_LF});         // CR after held CR
    send_bytes('{BYTE_CR, 8'h7A, BYTE_LF});           // released CR plus data
    send_bytes('{8'hFF, 8'h01, 8'h80, BYTE_NUL, BYTE_LF});
    send_bytes('{BYTE_LF, BYTE_CR, BYTE_LF});         // empty lines
  endtask

  // Tiny limits: overflow of data and of released CRs, and a zero limit.
  task automatic test_short_limits();
    write_max_len(16'd1);
    send_bytes('{8'h61, 8'h62, BYTE_CR, 8'h63, BYTE_LF});
    send_bytes('{BYTE_CR, BYTE_CR, BYTE_LF});
    write_max_len(16'd0);
    send_bytes('{8'h71, BYTE_CR, 8'h72, BYTE_LF, BYTE_LF});
  endtask

  // A long line that overruns a mid-size limit, sent with no idling on
  // either side.
  task automatic test_long_line();
    write_max_len(LONG_LIMIT);
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    for (int unsigned i = 0; i < LONG_LINE; i++) send_byte(byte_t'(8'h41 + i % 26));
    send_bytes('{BYTE_LF, BYTE_CR, BYTE_LF});
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  // Random lines across several limit settings; one phase runs without any
  // idling, and the sender now and then waits for a full drain.
  task automatic test_random_lines();
    logic [CFG_W-1:0] limits[7];
    int unsigned      start;
    limits = '{MAX_LINE_RESET, 16'd1, 16'($urandom_range(2, 16)), 16'd0, 16'hFFFF,
               16'($urandom_range(17, 300)), 16'($urandom_range(2, 40))};
    foreach (limits[p]) begin
      write_max_len(limits[p]);
      gaps_on   = (p != 2);
      stalls_on = (p != 2) && (p != 4);
      start = bytes_sent;
      while (bytes_sent - start < PHASE_BYTES) begin
        send_random_line();
        if ($urandom_range(0, 99) < 2) wait_drain();
      end
    end
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_endings();
    test_short_limits();
    test_long_line();
    test_random_lines();

    wait_drain();
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/crlfd_pkg.sv
sv/crlf_line_deframer.sv
bench/tb_crlf_line_deframer.sv
